### src/kpit_pkg.sv
// Shared types, codes and tables of the key and pad input translator.
package kpit_pkg;

  localparam int NUM_DIRS = 4;
  localparam int DIR_W = 2;
  localparam int NUM_SLOTS = NUM_DIRS + 1;
  localparam int SLOT_W = 3;
  localparam int NUM_BUTTONS = 12;
  localparam int MAX_SCANS = 6;
  localparam int TIME_W = 48;
  localparam int WIN_W = 24;
  localparam int KEY_W = 9;
  localparam int SCAN_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic CMD_KEY = 1'b0;
  localparam logic CMD_PAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_WIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIDE_WIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_WIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MENU_HOLD  = 3'd5;

  localparam logic [WIN_W-1:0] RST_CTRL_WIN   = 24'd1500000;
  localparam logic [WIN_W-1:0] RST_DECIDE_WIN = 24'd60000;
  localparam logic [WIN_W-1:0] RST_LETTER_WIN = 24'd250000;
  localparam logic [WIN_W-1:0] RST_REP_DELAY  = 24'd400000;
  localparam logic [WIN_W-1:0] RST_REP_PERIOD = 24'd60000;
  localparam logic [WIN_W-1:0] RST_MENU_HOLD  = 24'd3000000;

  localparam logic [KEY_W-1:0] KEY_TAB       = 9'd9;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 9'd8;
  localparam logic [KEY_W-1:0] KEY_DELETE    = 9'd127;
  localparam logic [KEY_W-1:0] KEY_ALT       = 9'd132;
  localparam logic [KEY_W-1:0] KEY_CTRL      = 9'd133;
  localparam logic [KEY_W-1:0] KEY_SHIFT     = 9'd134;
  localparam logic [KEY_W-1:0] KEY_F1        = 9'd135;
  localparam logic [KEY_W-1:0] KEY_F12_END   = 9'd147;
  localparam logic [KEY_W-1:0] KEY_INSERT    = 9'd147;
  localparam logic [KEY_W-1:0] KEY_PAGE_A    = 9'd148;
  localparam logic [KEY_W-1:0] KEY_PAGE_B    = 9'd149;
  localparam logic [KEY_W-1:0] KEY_PAGE_C    = 9'd150;
  localparam logic [KEY_W-1:0] KEY_HOME      = 9'd151;
  localparam logic [KEY_W-1:0] KEY_END       = 9'd152;
  localparam logic [KEY_W-1:0] KEY_ASCII_MAX = 9'd255;
  localparam logic [KEY_W-1:0] OUT_PAGE_A    = 9'd262;
  localparam logic [KEY_W-1:0] OUT_PAGE_B    = 9'd22;
  localparam logic [KEY_W-1:0] OUT_PAGE_C    = 9'd25;
  localparam logic [KEY_W-1:0] OUT_CTRL_TAB  = 9'd263;
  localparam logic [KEY_W-1:0] CHR_UPPER_A   = 9'd65;
  localparam logic [KEY_W-1:0] CHR_UNDERSCORE = 9'd95;
  localparam logic [KEY_W-1:0] CHR_LOWER_A   = 9'd97;
  localparam logic [KEY_W-1:0] CHR_LOWER_Z   = 9'd122;
  localparam logic [KEY_W-1:0] CTRL_MASK     = 9'h01f;
  localparam logic [KEY_W-1:0] CASE_OFFSET   = 9'd32;

  localparam int BTN_X = 6;

  localparam logic [KEY_W-1:0] DIR_CODE [NUM_DIRS] = '{9'd259, 9'd258, 9'd260, 9'd261};
  localparam logic [KEY_W-1:0] DIR_CHAR [NUM_DIRS] = '{9'd119, 9'd115, 9'd97, 9'd100};
  localparam int DIR_BIT [NUM_DIRS] = '{3, 2, 1, 0};

  localparam logic [SCAN_W-1:0] SCAN_TABLE [NUM_BUTTONS] = '{
    8'h4F, 8'h50, 8'h51, 8'h52, 8'd27, 8'd29, 8'd22, 8'd4, 8'd40, 8'd42, 8'd20, 8'd8
  };

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_QUIT   = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_ARROW     = 2'd1,
    MODE_TYPING    = 2'd2
  } dir_mode_t;

  typedef struct packed {
    logic [WIN_W-1:0] ctrl_win;
    logic [WIN_W-1:0] decide_win;
    logic [WIN_W-1:0] letter_win;
    logic [WIN_W-1:0] rep_delay;
    logic [WIN_W-1:0] rep_period;
    logic [WIN_W-1:0] menu_hold;
  } cfg_t;

  typedef struct packed {
    logic poll;
    logic held;
    logic letter_hit;
  } dir_ctl_t;

  function automatic logic signed [TIME_W+1:0] tdiff(logic [TIME_W-1:0] a,
                                                     logic [TIME_W-1:0] b);
    return $signed({2'b00, a}) - $signed({2'b00, b});
  endfunction

  function automatic logic signed [TIME_W+1:0] win_ext(logic [WIN_W-1:0] w);
    return $signed({{(TIME_W+2-WIN_W){1'b0}}, w});
  endfunction

endpackage

### src/key_and_pad_input_translator_unit.sv
// Top level of the key and pad input translator: input register, key and pad logic, result batch.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    cmd now_us key_pressed key_code buttons
//                                            menu_held close_request
// out      output     out_valid / out_ready  kind key_out scan_a..scan_f last
// cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data (always ready)
//
// An item is held in the input register and evaluated in one pass into a result batch of up to
// five slots (four direction keys, then a final key, quit or report result).
// Results leave one per cycle while out_ready is high, so an item occupies the batch until its
// last result is taken (not at all if it has none); the next item waits in the input register meanwhile.
// Reset clears all timing state and loads the register defaults; out_ready low holds the batch.
module key_and_pad_input_translator_unit #(
  parameter int SCAN_SLOTS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [kpit_pkg::TIME_W-1:0]   now_us,
  input  logic                          key_pressed,
  input  logic [kpit_pkg::KEY_W-1:0]    key_code,
  input  logic [kpit_pkg::NUM_BUTTONS-1:0] buttons,
  input  logic                          menu_held,
  input  logic                          close_request,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [kpit_pkg::KEY_W-1:0]    key_out,
  output logic [kpit_pkg::SCAN_W-1:0]   scan_a,
  output logic [kpit_pkg::SCAN_W-1:0]   scan_b,
  output logic [kpit_pkg::SCAN_W-1:0]   scan_c,
  output logic [kpit_pkg::SCAN_W-1:0]   scan_d,
  output logic [kpit_pkg::SCAN_W-1:0]   scan_e,
  output logic [kpit_pkg::SCAN_W-1:0]   scan_f,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kpit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kpit_pkg::WIN_W-1:0]    cfg_data
);
  import kpit_pkg::*;

  cfg_t cfg;

  logic                   stage_valid;
  logic                   s_cmd;
  logic [TIME_W-1:0]      s_now;
  logic                   s_pressed;
  logic [KEY_W-1:0]       s_key;
  logic [NUM_BUTTONS-1:0] s_buttons;
  logic                   s_menu;
  logic                   s_close;

  logic [TIME_W-1:0]      ctrl_time, ctrl_time_next;
  logic [TIME_W-1:0]      menu_start, menu_start_next;

  logic [NUM_SLOTS-1:0]   pending, pending_next;
  kind_t                  final_kind, final_kind_next;
  logic [KEY_W-1:0]       final_key, final_key_next;
  logic [SCAN_W-1:0]      final_scan [MAX_SCANS];
  logic [SCAN_W-1:0]      final_scan_next [MAX_SCANS];

  logic                   fire, out_take;
  logic                   ctrl_on, key_emit, ctrl_set;
  logic [KEY_W-1:0]       key_val;
  logic                   pad_quit, hold_quit;
  logic [SCAN_W-1:0]      scans [MAX_SCANS];
  logic [3:0]             prefix;
  dir_ctl_t               dctl [NUM_DIRS];
  logic [NUM_DIRS-1:0]    demit;
  logic [SLOT_W-1:0]      sel;
  logic [NUM_SLOTS-1:0]   sel_mask;
  logic                   show_scan;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ctrl_win   <= RST_CTRL_WIN;
      cfg.decide_win <= RST_DECIDE_WIN;
      cfg.letter_win <= RST_LETTER_WIN;
      cfg.rep_delay  <= RST_REP_DELAY;
      cfg.rep_period <= RST_REP_PERIOD;
      cfg.menu_hold  <= RST_MENU_HOLD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CTRL_WIN:   cfg.ctrl_win   <= cfg_data;
        CFG_DECIDE_WIN: cfg.decide_win <= cfg_data;
        CFG_LETTER_WIN: cfg.letter_win <= cfg_data;
        CFG_REP_DELAY:  cfg.rep_delay  <= cfg_data;
        CFG_REP_PERIOD: cfg.rep_period <= cfg_data;
        CFG_MENU_HOLD:  cfg.menu_hold  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // lowest pending slot goes out first
  always_comb begin
    sel = SLOT_W'(NUM_DIRS);
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) sel = SLOT_W'(i);
    end
    sel_mask  = NUM_SLOTS'(1) << sel;
    show_scan = (sel == SLOT_W'(NUM_DIRS));
  end

  assign out_valid = pending != '0;
  assign out_take  = out_valid && out_ready;
  assign last      = (pending & (pending - NUM_SLOTS'(1))) == '0;
  assign fire      = stage_valid && (!out_valid || (out_ready && last));
  assign in_ready  = !stage_valid || fire;

  always_comb begin
    kind    = show_scan ? final_kind : KIND_KEY;
    key_out = show_scan ? final_key : DIR_CODE[sel[DIR_W-1:0]];
    scan_a  = show_scan ? final_scan[0] : '0;
    scan_b  = show_scan ? final_scan[1] : '0;
    scan_c  = show_scan ? final_scan[2] : '0;
    scan_d  = show_scan ? final_scan[3] : '0;
    scan_e  = show_scan ? final_scan[4] : '0;
    scan_f  = show_scan ? final_scan[5] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_cmd     <= cmd;
      s_now     <= now_us;
      s_pressed <= key_pressed;
      s_key     <= key_code;
      s_buttons <= buttons;
      s_menu    <= menu_held;
      s_close   <= close_request;
    end
  end

  // key tap translation
  always_comb begin
    ctrl_on  = (ctrl_time != '0) && (tdiff(s_now, ctrl_time) < win_ext(cfg.ctrl_win));
    key_emit = 1'b0;
    ctrl_set = 1'b0;
    key_val  = s_key;
    if (s_pressed) begin
      unique case (s_key)
        KEY_CTRL: ctrl_set = 1'b1;
        KEY_ALT, KEY_SHIFT, KEY_INSERT, KEY_HOME, KEY_END: begin
        end
        KEY_DELETE: begin
          key_emit = 1'b1;
          key_val  = KEY_BACKSPACE;
        end
        KEY_PAGE_A: begin
          key_emit = 1'b1;
          key_val  = OUT_PAGE_A;
        end
        KEY_PAGE_B: begin
          key_emit = 1'b1;
          key_val  = OUT_PAGE_B;
        end
        KEY_PAGE_C: begin
          key_emit = 1'b1;
          key_val  = OUT_PAGE_C;
        end
        KEY_TAB: begin
          key_emit = 1'b1;
          key_val  = ctrl_on ? OUT_CTRL_TAB : KEY_TAB;
        end
        default: begin
          if (!((s_key >= KEY_F1 && s_key < KEY_F12_END) || s_key > KEY_ASCII_MAX)) begin
            key_emit = 1'b1;
            if (ctrl_on && ((s_key >= CHR_UPPER_A && s_key <= CHR_UNDERSCORE) ||
                            (s_key >= CHR_LOWER_A && s_key <= CHR_LOWER_Z))) begin
              key_val = s_key & CTRL_MASK;
            end
          end
        end
      endcase
    end
  end

  // pad poll: quit, menu timing, held scan codes
  always_comb begin
    hold_quit = s_menu && (menu_start != '0) &&
                (tdiff(s_now, menu_start) >= win_ext(cfg.menu_hold));
    pad_quit  = s_close || (s_menu && s_buttons[BTN_X]) || hold_quit;
    menu_start_next = menu_start;
    if (!(s_close || (s_menu && s_buttons[BTN_X]))) begin
      if (!s_menu) begin
        menu_start_next = '0;
      end else if (menu_start == '0) begin
        menu_start_next = s_now;
      end
    end

    for (int j = 0; j < MAX_SCANS; j++) begin
      scans[j] = '0;
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      prefix = 4'($countones(s_buttons & ((NUM_BUTTONS'(1) << i) - NUM_BUTTONS'(1))));
      for (int j = 0; j < MAX_SCANS; j++) begin
        if (s_buttons[i] && prefix == 4'(j) && j < SCAN_SLOTS) begin
          scans[j] = scans[j] | SCAN_TABLE[i];
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      dctl[d].poll       = fire && (s_cmd == CMD_PAD) && !pad_quit;
      dctl[d].held       = s_buttons[DIR_BIT[d]];
      dctl[d].letter_hit = fire && (s_cmd == CMD_KEY) && s_pressed &&
                           (s_key == DIR_CHAR[d] || s_key == DIR_CHAR[d] - CASE_OFFSET);
    end
  end

  for (genvar g = 0; g < NUM_DIRS; g++) begin : g_dir
    kpit_dir u_dir (
      .clk  (clk),
      .rst  (rst),
      .cfg  (cfg),
      .ctl  (dctl[g]),
      .now  (s_now),
      .emit (demit[g])
    );
  end

  always_comb begin
    ctrl_time_next  = ctrl_time;
    pending_next    = out_take ? (pending & ~sel_mask) : pending;
    final_kind_next = final_kind;
    final_key_next  = final_key;
    for (int j = 0; j < MAX_SCANS; j++) begin
      final_scan_next[j] = final_scan[j];
    end
    if (fire) begin
      final_key_next = '0;
      for (int j = 0; j < MAX_SCANS; j++) begin
        final_scan_next[j] = '0;
      end
      if (s_cmd == CMD_KEY) begin
        final_kind_next = KIND_KEY;
        final_key_next  = key_val;
        pending_next    = {key_emit, {NUM_DIRS{1'b0}}};
        if (ctrl_set) begin
          ctrl_time_next = s_now;
        end else if (key_emit) begin
          ctrl_time_next = '0;
        end
      end else if (pad_quit) begin
        final_kind_next = KIND_QUIT;
        pending_next    = {1'b1, {NUM_DIRS{1'b0}}};
      end else begin
        final_kind_next = KIND_REPORT;
        pending_next    = {1'b1, demit};
        for (int j = 0; j < MAX_SCANS; j++) begin
          final_scan_next[j] = scans[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      ctrl_time  <= '0;
      menu_start <= '0;
    end else begin
      pending    <= pending_next;
      ctrl_time  <= ctrl_time_next;
      if (fire && s_cmd == CMD_PAD) menu_start <= menu_start_next;
    end
  end

  always_ff @(posedge clk) begin
    final_kind <= final_kind_next;
    final_key  <= final_key_next;
    for (int j = 0; j < MAX_SCANS; j++) begin
      final_scan[j] <= final_scan_next[j];
    end
  end

endmodule

### src/kpit_dir.sv
// One pad direction: hold timing, arrow or typing decision, and auto-repeat.
module kpit_dir (
  input  logic                        clk,
  input  logic                        rst,
  input  kpit_pkg::cfg_t              cfg,
  input  kpit_pkg::dir_ctl_t          ctl,
  input  logic [kpit_pkg::TIME_W-1:0] now,
  output logic                        emit
);
  import kpit_pkg::*;

  logic [TIME_W-1:0] press_time, press_time_next;
  logic [TIME_W-1:0] letter_time, letter_time_next;
  logic [TIME_W-1:0] next_repeat, next_repeat_next;
  dir_mode_t         mode, mode_next;

  logic [TIME_W-1:0] press_eff;
  dir_mode_t         mode_eff;
  logic              typing_old, typing_new;
  logic              decide_due, repeat_due;
  logic [TIME_W:0]   sum_delay, sum_period;
  logic [TIME_W-1:0] sat_delay, sat_period;

  function automatic logic typing(logic [TIME_W-1:0] p, logic [TIME_W-1:0] l,
                                  logic [WIN_W-1:0] lw);
    logic signed [TIME_W+1:0] since;
    since = tdiff(p, l);
    return (l != '0) && (since < win_ext(lw)) && ((since + win_ext(lw)) > 0);
  endfunction

  always_comb begin
    press_eff  = (press_time == '0) ? now : press_time;
    mode_eff   = (press_time == '0) ? MODE_UNDECIDED : mode;
    typing_old = typing(press_time, letter_time, cfg.letter_win);
    typing_new = typing(press_eff, letter_time, cfg.letter_win);
    decide_due = tdiff(now, press_eff) >= win_ext(cfg.decide_win);
    repeat_due = now >= next_repeat;
    sum_delay  = {1'b0, now} + {{(TIME_W+1-WIN_W){1'b0}}, cfg.rep_delay};
    sum_period = {1'b0, now} + {{(TIME_W+1-WIN_W){1'b0}}, cfg.rep_period};
    sat_delay  = sum_delay[TIME_W] ? '1 : sum_delay[TIME_W-1:0];
    sat_period = sum_period[TIME_W] ? '1 : sum_period[TIME_W-1:0];

    press_time_next  = press_time;
    letter_time_next = ctl.letter_hit ? now : letter_time;
    next_repeat_next = next_repeat;
    mode_next        = mode;
    emit             = 1'b0;

    if (ctl.poll) begin
      if (!ctl.held) begin
        emit            = (press_time != '0) && (mode == MODE_UNDECIDED) && !typing_old;
        press_time_next = '0;
      end else begin
        press_time_next = press_eff;
        mode_next       = mode_eff;
        if (mode_eff == MODE_UNDECIDED && decide_due) begin
          if (typing_new) begin
            mode_next = MODE_TYPING;
          end else begin
            mode_next        = MODE_ARROW;
            emit             = 1'b1;
            next_repeat_next = sat_delay;
          end
        end else if (mode_eff == MODE_ARROW && repeat_due) begin
          emit             = 1'b1;
          next_repeat_next = sat_period;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_time  <= '0;
      letter_time <= '0;
      next_repeat <= '0;
      mode        <= MODE_UNDECIDED;
    end else begin
      press_time  <= press_time_next;
      letter_time <= letter_time_next;
      next_repeat <= next_repeat_next;
      mode        <= mode_next;
    end
  end

endmodule
